// ===== hw/rtl/mer_pkg.sv =====
// shared types and constants of the midpoint ellipse rasterizer
`default_nettype none

package mer_pkg;

  // input item operation codes
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  // operand pairs of the shared multiplier
  typedef enum logic [2:0] {
    MUL_AA,
    MUL_BB,
    MUL_ASQ_B,
    MUL_XX,
    MUL_YM,
    MUL_BSQ_TMP,
    MUL_ASQ_TMP,
    MUL_ASQ_BSQ
  } mul_sel_e;

  localparam int unsigned PIX_PER_STEP = 4;
  localparam logic [1:0]  LAST_PIX     = 2'(PIX_PER_STEP - 1);

  typedef struct packed {
    logic       start_load;
    mul_sel_e   mul_sel;
    logic       su_asq;
    logic       su_bsq;
    logic       su_fin;
    logic       xx_save;
    logic       tmp_load;
    logic       acc_load;
    logic       acc_add;
    logic       r2_fin;
    logic       adv1;
    logic       adv2;
    logic       emit_pix;
    logic       emit_done;
    logic [1:0] pix_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic slope_lt;
    logic pos_y_nz;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mer_ctrl.sv =====
// controller state machine of the midpoint ellipse rasterizer
`default_nettype none

module mer_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            op_i,
  output logic                 in_stall_o,
  input  wire mer_pkg::dp_sts_t sts_i,
  output mer_pkg::dp_cmd_t     cmd_o
);
  import mer_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SU1,
    ST_SU2,
    ST_SU3,
    ST_SU4,
    ST_EMIT,
    ST_ADV1,
    ST_ADV2,
    ST_L1,
    ST_L2,
    ST_L3,
    ST_L4,
    ST_L5,
    ST_L6,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_R1,
    PH_R2
  } phase_e;

  state_e     state_q;
  phase_e     phase_q;
  logic [1:0] k_q;
  logic       emit_r1_q;
  logic       in_acc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_AA;
    cmd_o.pix_idx = k_q;
    case (state_q)
      ST_IDLE: cmd_o.start_load = in_acc && (op_i == OP_START);
      ST_SU1:  cmd_o.mul_sel = MUL_AA;
      ST_SU2: begin
        cmd_o.mul_sel = MUL_BB;
        cmd_o.su_asq  = 1'b1;
      end
      ST_SU3: begin
        cmd_o.mul_sel = MUL_ASQ_B;
        cmd_o.su_bsq  = 1'b1;
      end
      ST_SU4:  cmd_o.su_fin = 1'b1;
      ST_EMIT: cmd_o.emit_pix = sts_i.out_free;
      ST_ADV1: cmd_o.adv1 = 1'b1;
      ST_ADV2: cmd_o.adv2 = 1'b1;
      ST_L1:   cmd_o.mul_sel = MUL_XX;
      ST_L2: begin
        cmd_o.mul_sel = MUL_YM;
        cmd_o.xx_save = 1'b1;
      end
      ST_L3: begin
        cmd_o.mul_sel  = MUL_BSQ_TMP;
        cmd_o.tmp_load = 1'b1;
      end
      ST_L4: begin
        cmd_o.mul_sel  = MUL_ASQ_TMP;
        cmd_o.acc_load = 1'b1;
      end
      ST_L5: begin
        cmd_o.mul_sel = MUL_ASQ_BSQ;
        cmd_o.acc_add = 1'b1;
      end
      ST_L6:   cmd_o.r2_fin = 1'b1;
      ST_DONE: cmd_o.emit_done = sts_i.out_free;
      default: cmd_o.mul_sel = MUL_AA;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_IDLE;
      k_q       <= '0;
      emit_r1_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            k_q <= '0;
            if (op_i == OP_START) begin
              state_q <= ST_SU1;
            end else if (phase_q == PH_R1) begin
              emit_r1_q <= 1'b1;
              state_q   <= ST_EMIT;
            end else if (phase_q == PH_R2 && sts_i.pos_y_nz) begin
              state_q <= ST_ADV2;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_SU1: state_q <= ST_SU2;
        ST_SU2: state_q <= ST_SU3;
        ST_SU3: state_q <= ST_SU4;
        ST_SU4: begin
          phase_q <= PH_R1;
          state_q <= ST_IDLE;
        end
        ST_EMIT: begin
          if (sts_i.out_free) begin
            k_q <= k_q + 2'd1;
            if (k_q == LAST_PIX) begin
              if (!emit_r1_q) begin
                state_q <= ST_IDLE;
              end else if (sts_i.slope_lt) begin
                state_q <= ST_ADV1;
              end else begin
                phase_q <= PH_R2;
                state_q <= ST_L1;
              end
            end
          end
        end
        ST_ADV1: state_q <= ST_IDLE;
        ST_ADV2: begin
          emit_r1_q <= 1'b0;
          k_q       <= '0;
          state_q   <= ST_EMIT;
        end
        ST_L1: state_q <= ST_L2;
        ST_L2: state_q <= ST_L3;
        ST_L3: state_q <= ST_L4;
        ST_L4: state_q <= ST_L5;
        ST_L5: state_q <= ST_L6;
        ST_L6: state_q <= ST_IDLE;
        ST_DONE: begin
          if (sts_i.out_free) begin
            phase_q <= PH_IDLE;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mer_dpath.sv =====
// datapath of the midpoint ellipse rasterizer: walk registers, shared multiplier, output register
`default_nettype none

module mer_dpath #(
  parameter int unsigned AXIS_BITS  = 10,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire mer_pkg::dp_cmd_t             cmd_i,
  output mer_pkg::dp_sts_t                  sts_o,
  input  wire logic signed [COORD_BITS-1:0] center_x_i,
  input  wire logic signed [COORD_BITS-1:0] center_y_i,
  input  wire logic        [AXIS_BITS-1:0]  semi_a_i,
  input  wire logic        [AXIS_BITS-1:0]  semi_b_i,
  input  wire logic                         out_stall_i,
  output logic                              out_valid_o,
  output logic signed [COORD_BITS:0]        pixel_x_o,
  output logic signed [COORD_BITS:0]        pixel_y_o,
  output logic                              last_of_group_o,
  output logic                              done_res_o
);
  import mer_pkg::*;

  localparam int unsigned DW = (4 * AXIS_BITS + 4 > 64) ? 64 : 4 * AXIS_BITS + 4;
  localparam int unsigned SQ = 2 * AXIS_BITS;
  localparam int unsigned PW = AXIS_BITS + 2;
  localparam int unsigned OW = 2 * AXIS_BITS + 4;
  localparam int unsigned PX = COORD_BITS + 1;
  localparam int unsigned EW = (PW > PX) ? PW : PX;

  logic        [AXIS_BITS-1:0]  a_q, a_d;
  logic signed [COORD_BITS-1:0] mid_x_q, mid_x_d, mid_y_q, mid_y_d;
  logic signed [PW-1:0]         pos_x_q, pos_x_d, pos_y_q, pos_y_d, ym;
  logic        [SQ-1:0]         asq_q, asq_d, bsq_q, bsq_d;
  logic        [DW-1:0]         slope_x_q, slope_x_d, slope_y_q, slope_y_d;
  logic        [DW-1:0]         dec_q, dec_d, tmp_q, tmp_d, acc_q, acc_d, prod_q;
  logic        [DW-1:0]         asq_w, bsq_w, sx_n, sy_n, su_sum, r2_sum;
  logic signed [OW-1:0]         mop_a, mop_b;
  logic signed [2*OW-1:0]       mprod;
  logic signed [EW-1:0]         mx_e, my_e, px_e, py_e, pix_x_e, pix_y_e;
  logic                         out_valid_q;
  logic signed [PX-1:0]         pix_x_q, pix_y_q;
  logic                         last_q, done_q;

  // sum plus a quarter fraction, truncated toward zero
  function automatic logic [DW-1:0] trunc_q(input logic [DW-1:0] s, input logic [1:0] r);
    return (s[DW-1] && (r != 2'b00)) ? s + DW'(1) : s;
  endfunction

  assign asq_w  = DW'(asq_q);
  assign bsq_w  = DW'(bsq_q);
  assign ym     = pos_y_q - PW'(1);
  assign su_sum = bsq_w - prod_q + (asq_w >> 2);
  assign r2_sum = acc_q - prod_q + (bsq_w >> 2);
  assign sx_n   = slope_x_q + (bsq_w << 1);
  assign sy_n   = slope_y_q - (asq_w << 1);

  // shared multiplier operand selection
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_AA: begin
        mop_a = OW'(a_q);
        mop_b = OW'(a_q);
      end
      MUL_BB: begin
        mop_a = OW'(pos_y_q);
        mop_b = OW'(pos_y_q);
      end
      MUL_ASQ_B: begin
        mop_a = OW'(asq_q);
        mop_b = OW'(pos_y_q);
      end
      MUL_XX: begin
        mop_a = OW'(pos_x_q);
        mop_b = OW'(pos_x_q);
      end
      MUL_YM: begin
        mop_a = OW'(ym);
        mop_b = OW'(ym);
      end
      MUL_BSQ_TMP: begin
        mop_a = OW'(bsq_q);
        mop_b = tmp_q[OW-1:0];
      end
      MUL_ASQ_TMP: begin
        mop_a = OW'(asq_q);
        mop_b = tmp_q[OW-1:0];
      end
      MUL_ASQ_BSQ: begin
        mop_a = OW'(asq_q);
        mop_b = OW'(bsq_q);
      end
      default: begin
        mop_a = '0;
        mop_b = '0;
      end
    endcase
  end

  assign mprod = mop_a * mop_b;

  always_comb begin
    a_d       = a_q;
    mid_x_d   = mid_x_q;
    mid_y_d   = mid_y_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    asq_d     = asq_q;
    bsq_d     = bsq_q;
    slope_x_d = slope_x_q;
    slope_y_d = slope_y_q;
    dec_d     = dec_q;
    tmp_d     = tmp_q;
    acc_d     = acc_q;
    if (cmd_i.start_load) begin
      a_d       = semi_a_i;
      mid_x_d   = center_x_i;
      mid_y_d   = center_y_i;
      pos_x_d   = '0;
      pos_y_d   = PW'(semi_b_i);
      slope_x_d = '0;
    end
    if (cmd_i.su_asq) asq_d = prod_q[SQ-1:0];
    if (cmd_i.su_bsq) bsq_d = prod_q[SQ-1:0];
    if (cmd_i.su_fin) begin
      slope_y_d = prod_q << 1;
      dec_d     = trunc_q(su_sum, asq_q[1:0]);
    end
    if (cmd_i.xx_save)  tmp_d = prod_q + DW'(pos_x_q);
    if (cmd_i.tmp_load) tmp_d = prod_q;
    if (cmd_i.acc_load) acc_d = prod_q;
    if (cmd_i.acc_add)  acc_d = acc_q + prod_q;
    if (cmd_i.r2_fin)   dec_d = trunc_q(r2_sum, bsq_q[1:0]);
    if (cmd_i.adv1) begin
      pos_x_d   = pos_x_q + PW'(1);
      slope_x_d = sx_n;
      if (dec_q[DW-1]) begin
        dec_d = dec_q + sx_n + bsq_w;
      end else begin
        pos_y_d   = pos_y_q - PW'(1);
        slope_y_d = sy_n;
        dec_d     = dec_q + sx_n + bsq_w - sy_n;
      end
    end
    if (cmd_i.adv2) begin
      pos_y_d   = pos_y_q - PW'(1);
      slope_y_d = sy_n;
      if (!dec_q[DW-1]) begin
        dec_d = dec_q + asq_w - sy_n;
      end else begin
        pos_x_d   = pos_x_q + PW'(1);
        slope_x_d = sx_n;
        dec_d     = dec_q + sx_n - sy_n + asq_w;
      end
    end
  end

  // symmetric pixel of the current point
  assign mx_e = EW'(mid_x_q);
  assign my_e = EW'(mid_y_q);
  assign px_e = EW'(pos_x_q);
  assign py_e = EW'(pos_y_q);

  always_comb begin
    case (cmd_i.pix_idx)
      2'd0: begin
        pix_x_e = mx_e + px_e;
        pix_y_e = my_e - py_e;
      end
      2'd1: begin
        pix_x_e = mx_e - px_e;
        pix_y_e = my_e + py_e;
      end
      2'd2: begin
        pix_x_e = mx_e + px_e;
        pix_y_e = my_e + py_e;
      end
      default: begin
        pix_x_e = mx_e - px_e;
        pix_y_e = my_e - py_e;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    mid_x_q   <= mid_x_d;
    mid_y_q   <= mid_y_d;
    pos_x_q   <= pos_x_d;
    pos_y_q   <= pos_y_d;
    asq_q     <= asq_d;
    bsq_q     <= bsq_d;
    slope_x_q <= slope_x_d;
    slope_y_q <= slope_y_d;
    dec_q     <= dec_d;
    tmp_q     <= tmp_d;
    acc_q     <= acc_d;
    prod_q    <= mprod[DW-1:0];
    if (cmd_i.emit_pix) begin
      pix_x_q <= pix_x_e[PX-1:0];
      pix_y_q <= pix_y_e[PX-1:0];
      last_q  <= (cmd_i.pix_idx == LAST_PIX);
      done_q  <= 1'b0;
    end else if (cmd_i.emit_done) begin
      pix_x_q <= '0;
      pix_y_q <= '0;
      last_q  <= 1'b1;
      done_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_pix || cmd_i.emit_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.slope_lt = (slope_x_q < slope_y_q);
  assign sts_o.pos_y_nz = (pos_y_q != '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign pixel_x_o       = pix_x_q;
  assign pixel_y_o       = pix_y_q;
  assign last_of_group_o = last_q;
  assign done_res_o      = done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/midpoint_ellipse_rasterizer_core.sv =====
// Midpoint ellipse rasterizer, top level.
//
// Input channel (in_valid_i / in_stall_o): op_i = start loads center and semi-axes and
// gives no result; op_i = step gives the four symmetric pixels of the current point
// (the fourth with last_of_group_o set) and advances the walk, or one item with
// done_res_o and last_of_group_o set and zero coordinates once the walk has ended.
// Output channel (out_valid_o / out_stall_i) holds one registered result item.
// One item is worked on at a time; in_stall_o is low only while the controller idles.
// Order of work per accepted item, after the idle state that takes it:
// start: four setup states with three products on the shared multiplier.
// Step in region 1: output of the four pixels, then the advance state.
// Step at the region change: output of the four pixels, then the states for the
// region 2 decision value (five products on the same multiplier).
// Step in region 2: the advance state, then output of the four pixels. Done item: the done state.
// Pixel output waits on the single output register: while out_stall_i holds the
// registered item, no new pixel or done item is loaded.
// Reset puts the walk in the finished state, so a step before any start gives a done item.
`default_nettype none

module midpoint_ellipse_rasterizer_core #(
  parameter int unsigned AXIS_BITS  = 10,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         op_i,
  input  wire logic signed [COORD_BITS-1:0] center_x_i,
  input  wire logic signed [COORD_BITS-1:0] center_y_i,
  input  wire logic        [AXIS_BITS-1:0]  semi_a_i,
  input  wire logic        [AXIS_BITS-1:0]  semi_b_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [COORD_BITS:0]        pixel_x_o,
  output logic signed [COORD_BITS:0]        pixel_y_o,
  output logic                              last_of_group_o,
  output logic                              done_res_o
);
  import mer_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  mer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  mer_dpath #(
    .AXIS_BITS  (AXIS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .sts_o           (dp_sts),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .semi_a_i        (semi_a_i),
    .semi_b_i        (semi_b_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .last_of_group_o (last_of_group_o),
    .done_res_o      (done_res_o)
  );

  // a done item always closes its group and carries no pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> last_of_group_o && pixel_x_o == '0 && pixel_y_o == '0)
    else $error("done item malformed");

  // nothing is pushed into the output register while a new item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !dp_cmd.emit_pix && !dp_cmd.emit_done)
    else $error("output loaded while accepting an item");

  // the output register is only loaded when it can take the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !dp_cmd.emit_pix && !dp_cmd.emit_done)
    else $error("stalled output overwritten");

endmodule

`default_nettype wire
